// File: src/psc_pkg.sv
`timescale 1ns / 1ps
package psc_pkg;
    localparam int COORD_W = 16;
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SC_LEFT = 3'd0,
        CFG_SC_TOP = 3'd1,
        CFG_SC_RIGHT = 3'd2,
        CFG_SC_BOTTOM = 3'd3,
        CFG_ORG_X = 3'd4,
        CFG_ORG_Y = 3'd5
    } t_cfg_idx;
    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_LINE = 1'b1;
endpackage

// File: src/psc_div.sv
`timescale 1ns / 1ps
module psc_div #(
    parameter int NW = 40,
    parameter int DW = 20
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [NW-1:0] o_quo
);
    // restoring divider, one quotient bit per stage, fully pipelined
    logic [NW-1:0] r_rem [NW+1];
    logic [NW-1:0] r_q   [NW+1];
    logic [DW-1:0] r_d   [NW+1];
    logic          r_neg [NW+1];
    logic [NW-1:0] n_num_abs;
    logic [DW-1:0] n_den_abs;

    assign n_num_abs = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign n_den_abs = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_q[0]   <= n_num_abs;
            r_d[0]   <= n_den_abs;
            r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [NW:0] n_sh;
        logic [NW:0] n_diff;
        assign n_sh   = {r_rem[s], r_q[s][NW-1-s]};
        assign n_diff = n_sh - (NW+1)'(r_d[s]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                if (!n_diff[NW]) begin
                    r_rem[s+1] <= n_diff[NW-1:0];
                    r_q[s+1]   <= r_q[s] | (NW'(1) << (NW-1-s));
                end else begin
                    r_rem[s+1] <= n_sh[NW-1:0];
                    r_q[s+1]   <= r_q[s] & ~(NW'(1) << (NW-1-s));
                end
            end
        end
    end

    assign o_quo = r_neg[NW] ? NW'(-r_q[NW]) : r_q[NW];
endmodule

// File: src/primitive_scissor_clipper.sv
`timescale 1ns / 1ps
// channel  | direction | handshake
// ---------+-----------+-----------------------------------------
// cfg      | in        | i_cfg_valid & o_cfg_ready, index + data
// command  | in        | i_start & !o_busy
// result   | out       | o_valid strobe, one cycle, no back-pressure
//
// one primitive per cycle; the path runs through the stage 0 register, six chained clip steps
// (each a product register, a divider pipeline and an apply register) and the output register
// o_busy is always low; the receiver cannot stall so nothing ever holds
// synchronous active-low reset clears valid bits, zeroes config registers but sets scissor right and bottom to all ones
module primitive_scissor_clipper #(
    parameter int COORD_WIDTH = psc_pkg::COORD_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_kind,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     i_size_w_or_end_x,
    input  logic signed [COORD_WIDTH-1:0]     i_size_h_or_end_y,
    input  logic signed [COORD_WIDTH-1:0]     i_tex_x,
    input  logic signed [COORD_WIDTH-1:0]     i_tex_y,
    input  logic signed [COORD_WIDTH-1:0]     i_tex_w,
    input  logic signed [COORD_WIDTH-1:0]     i_tex_h,
    output logic                              o_valid,
    output logic                              o_out_kind,
    output logic signed [COORD_WIDTH:0]       o_out_x,
    output logic signed [COORD_WIDTH:0]       o_out_y,
    output logic signed [COORD_WIDTH:0]       o_out_w_or_end_x,
    output logic signed [COORD_WIDTH:0]       o_out_h_or_end_y,
    output logic signed [COORD_WIDTH:0]       o_out_tex_x,
    output logic signed [COORD_WIDTH:0]       o_out_tex_y,
    output logic signed [COORD_WIDTH:0]       o_out_tex_w,
    output logic signed [COORD_WIDTH:0]       o_out_tex_h
);
    import psc_pkg::*;

    // internal values: coords, spans, products
    localparam int VW = COORD_WIDTH + 4;
    localparam int NW = 2 * VW;
    localparam int DL = NW + 2;
    localparam int NST = 6;

    typedef logic signed [VW-1:0] t_v;
    typedef struct packed {
        logic kind;
        logic drop;
        t_v   x;
        t_v   y;
        t_v   w;
        t_v   h;
        t_v   tx;
        t_v   ty;
        t_v   tw;
        t_v   th;
    } t_item;

    logic signed [COORD_WIDTH-1:0] r_sl, r_st, r_sr, r_sb, r_ox, r_oy;
    t_v sl, st, sr, sb;
    logic clip_en;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;
    assign sl = VW'(r_sl);
    assign st = VW'(r_st);
    assign sr = VW'(r_sr);
    assign sb = VW'(r_sb);
    assign clip_en = (r_sr >= r_sl) && (r_sb >= r_st);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sl <= '0;
            r_st <= '0;
            r_sr <= '1;
            r_sb <= '1;
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SC_LEFT:   r_sl <= i_cfg_data;
                CFG_SC_TOP:    r_st <= i_cfg_data;
                CFG_SC_RIGHT:  r_sr <= i_cfg_data;
                CFG_SC_BOTTOM: r_sb <= i_cfg_data;
                CFG_ORG_X:     r_ox <= i_cfg_data;
                CFG_ORG_Y:     r_oy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: origin, ordering, trivial reject
    t_item n_s0;
    logic  r_v0;
    t_item r_s0;
    always_comb begin
        t_v xa, ya, xb, yb;
        n_s0 = '0;
        xa = VW'(i_pos_x) + VW'(r_ox);
        ya = VW'(i_pos_y) + VW'(r_oy);
        xb = VW'(i_size_w_or_end_x) + VW'(r_ox);
        yb = VW'(i_size_h_or_end_y) + VW'(r_oy);
        n_s0.kind = i_kind;
        if (i_kind == KIND_LINE) begin
            if (xa > xb) begin
                n_s0.x = xb; n_s0.y = yb; n_s0.w = xa; n_s0.h = ya;
            end else begin
                n_s0.x = xa; n_s0.y = ya; n_s0.w = xb; n_s0.h = yb;
            end
            if (clip_en && ((n_s0.x > sr && n_s0.w > sr) || (n_s0.x < sl && n_s0.w < sl)
                || (n_s0.y > sb && n_s0.h > sb) || (n_s0.y < st && n_s0.h < st)))
                n_s0.drop = 1'b1;
        end else begin
            n_s0.x = xa; n_s0.y = ya;
            n_s0.w = VW'(i_size_w_or_end_x);
            n_s0.h = VW'(i_size_h_or_end_y);
            n_s0.tx = VW'(i_tex_x);
            n_s0.ty = VW'(i_tex_y);
            n_s0.tw = VW'(i_tex_w);
            n_s0.th = VW'(i_tex_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_start;
        r_s0 <= n_s0;
    end

    // six clip steps, each: setup product, divide, apply
    t_item s_in  [NST+1];
    logic  v_in  [NST+1];
    assign s_in[0] = r_s0;
    assign v_in[0] = r_v0;

    for (genvar k = 0; k < NST; k++) begin : g_step
        t_item n_it;
        logic signed [VW-1:0] n_a, n_b, n_den;
        logic n_act, n_dz;
        logic signed [NW-1:0] r_prod;
        logic signed [VW-1:0] r_den;
        t_item r_it;
        logic r_act, r_v, r_dz;
        logic signed [NW-1:0] quo;
        t_item d_it [DL];
        logic  d_v  [DL];
        logic  d_act[DL];
        logic  d_dz [DL];
        t_item n_out;

        always_comb begin
            t_item it;
            it = s_in[k];
            n_act = 1'b0; n_a = '0; n_b = '0; n_den = '1;
            if (clip_en && !it.drop) begin
                if (it.kind == KIND_RECT) begin
                    case (k)
                        0: begin
                            n_act = it.x < sl; n_a = it.tw; n_b = sl - it.x; n_den = it.w;
                        end
                        1: begin
                            n_act = it.y < st; n_a = it.th; n_b = st - it.y; n_den = it.h;
                        end
                        2: begin
                            n_act = (it.x + it.w) > sr; n_a = it.tw;
                            n_b = sr - it.x - it.w; n_den = it.w;
                        end
                        3: begin
                            n_act = (it.y + it.h) > sb; n_a = it.th;
                            n_b = sb - it.y - it.h; n_den = it.h;
                        end
                        default: n_act = 1'b0;
                    endcase
                end else begin
                    case (k)
                        0: begin
                            n_act = it.x < sl; n_a = sl - it.x;
                            n_b = it.h - it.y; n_den = it.w - it.x;
                        end
                        1: begin
                            n_act = it.w > sr; n_a = sr - it.w;
                            n_b = it.h - it.y; n_den = it.w - it.x;
                        end
                        2: begin
                            n_act = it.y < st; n_a = st - it.y;
                            n_b = it.w - it.x; n_den = it.h - it.y;
                        end
                        3: begin
                            n_act = it.h < st; n_a = st - it.h;
                            n_b = it.w - it.x; n_den = it.h - it.y;
                        end
                        4: begin
                            n_act = it.y > sb; n_a = sb - it.y;
                            n_b = it.w - it.x; n_den = it.h - it.y;
                        end
                        default: begin
                            n_act = it.h > sb; n_a = sb - it.h;
                            n_b = it.w - it.x; n_den = it.h - it.y;
                        end
                    endcase
                end
            end
            n_dz = (n_den == '0);
            n_it = it;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else          r_v <= v_in[k];
            r_prod <= NW'(n_a) * NW'(n_b);
            r_den  <= n_dz ? t_v'(1) : n_den;
            r_it   <= n_it;
            r_act  <= n_act;
            r_dz   <= n_dz;
        end

        psc_div #(.NW(NW), .DW(VW)) u_div (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_num (r_prod),
            .i_den (r_den),
            .o_quo (quo)
        );

        assign d_it[0] = r_it;
        assign d_v[0] = r_v;
        assign d_act[0] = r_act;
        assign d_dz[0] = r_dz;
        for (genvar j = 1; j < DL; j++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) d_v[j] <= 1'b0;
                else          d_v[j] <= d_v[j-1];
                d_it[j]  <= d_it[j-1];
                d_act[j] <= d_act[j-1];
                d_dz[j]  <= d_dz[j-1];
            end
        end

        always_comb begin
            t_item it;
            t_v q;
            it = d_it[DL-1];
            q = VW'(quo);
            if (d_act[DL-1]) begin
                if (it.kind == KIND_RECT) begin
                    case (k)
                        0: begin
                            if (!d_dz[DL-1]) begin
                                it.tx = it.tx + q; it.tw = it.tw - q;
                            end
                            it.w = it.w - (sl - it.x); it.x = sl;
                        end
                        1: begin
                            if (!d_dz[DL-1]) begin
                                it.ty = it.ty + q; it.th = it.th - q;
                            end
                            it.h = it.h - (st - it.y); it.y = st;
                        end
                        2: begin
                            if (!d_dz[DL-1]) it.tw = it.tw + q;
                            it.w = sr - it.x;
                        end
                        default: begin
                            if (!d_dz[DL-1]) it.th = it.th + q;
                            it.h = sb - it.y;
                        end
                    endcase
                end else if (d_dz[DL-1]) begin
                    it.drop = 1'b1;
                end else begin
                    case (k)
                        0: begin it.y = it.y + q; it.x = sl; end
                        1: begin it.h = it.h + q; it.w = sr; end
                        2: begin it.x = it.x + q; it.y = st; end
                        3: begin it.w = it.w + q; it.h = st; end
                        4: begin it.x = it.x + q; it.y = sb; end
                        default: begin it.w = it.w + q; it.h = sb; end
                    endcase
                end
            end
            n_out = it;
        end

        t_item r_out;
        logic  r_vo;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vo <= 1'b0;
            else          r_vo <= d_v[DL-1];
            r_out <= n_out;
        end
        assign s_in[k+1] = r_out;
        assign v_in[k+1] = r_vo;
    end

    // final accept test and output register
    t_item fin;
    logic  n_emit;
    assign fin = s_in[NST];
    always_comb begin
        if (fin.drop) n_emit = 1'b0;
        else if (fin.kind == KIND_RECT) n_emit = (fin.w > 0) && (fin.h > 0);
        else n_emit = !((fin.x == fin.w) && (fin.y == fin.h));
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= v_in[NST] && n_emit;
        o_out_kind       <= fin.kind;
        o_out_x          <= fin.x[COORD_WIDTH:0];
        o_out_y          <= fin.y[COORD_WIDTH:0];
        o_out_w_or_end_x <= fin.w[COORD_WIDTH:0];
        o_out_h_or_end_y <= fin.h[COORD_WIDTH:0];
        o_out_tex_x      <= fin.tx[COORD_WIDTH:0];
        o_out_tex_y      <= fin.ty[COORD_WIDTH:0];
        o_out_tex_w      <= fin.tw[COORD_WIDTH:0];
        o_out_tex_h      <= fin.th[COORD_WIDTH:0];
    end
    assign o_valid = r_ov;
endmodule

// File: dv/tb_primitive_scissor_clipper.sv
`timescale 1ns / 1ps
module tb_primitive_scissor_clipper;
    import psc_pkg::*;

    localparam int W = COORD_W;
    localparam int LAT = 8 * (2 * W + 8) + 40;
    localparam int LIMIT = 600000;
    localparam int N_RAND = 1650;
    localparam int N_CALM = 200;

    typedef longint vec8_t [8];
    typedef longint vec6_t [6];

    typedef enum int {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_t;

    typedef struct {
        logic  kind;
        vec8_t v;
    } prim_t;

    typedef struct {
        logic                 kind;
        logic signed [W:0]    f [8];
    } clip_t;

    typedef struct {
        int    ph;
        chk_t  how;
        prim_t p;
        vec8_t e;
    } row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [W-1:0]          i_cfg_data = '0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic                  i_kind = 1'b0;
    logic signed [W-1:0]   i_pos_x = '0, i_pos_y = '0;
    logic signed [W-1:0]   i_size_w_or_end_x = '0, i_size_h_or_end_y = '0;
    logic signed [W-1:0]   i_tex_x = '0, i_tex_y = '0, i_tex_w = '0, i_tex_h = '0;
    logic                  o_valid;
    logic                  o_out_kind;
    logic signed [W:0]     o_out_x, o_out_y, o_out_w_or_end_x, o_out_h_or_end_y;
    logic signed [W:0]     o_out_tex_x, o_out_tex_y, o_out_tex_w, o_out_tex_h;

    primitive_scissor_clipper u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scissor and origin as the block should hold them
    longint sc_left = 0, sc_top = 0, sc_right = -1, sc_bottom = -1;
    longint org_x = 0, org_y = 0;

    clip_t  clip_q [$];
    int     n_err = 0;
    longint cycles = 0;
    row_t   rows [$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint qdiv(longint n, longint d);
        return n / d;
    endfunction

    function automatic bit clip_prim(prim_t p, output clip_t r);
        longint x, y, w, h, tx, ty, tw, th, d, q, t, xb, yb;
        bit on;
        on = sc_right >= sc_left && sc_bottom >= sc_top;
        r.kind = p.kind;
        if (p.kind == KIND_RECT) begin
            x = p.v[0] + org_x; y = p.v[1] + org_y; w = p.v[2]; h = p.v[3];
            tx = p.v[4]; ty = p.v[5]; tw = p.v[6]; th = p.v[7];
            if (on) begin
                if (x < sc_left) begin
                    d = sc_left - x;
                    if (w != 0) begin
                        q = qdiv(tw * d, w); tx += q; tw -= q;
                    end
                    w -= d; x = sc_left;
                end
                if (y < sc_top) begin
                    d = sc_top - y;
                    if (h != 0) begin
                        q = qdiv(th * d, h); ty += q; th -= q;
                    end
                    h -= d; y = sc_top;
                end
                if (x + w > sc_right) begin
                    if (w != 0) tw += qdiv(tw * (sc_right - x - w), w);
                    w = sc_right - x;
                end
                if (y + h > sc_bottom) begin
                    if (h != 0) th += qdiv(th * (sc_bottom - y - h), h);
                    h = sc_bottom - y;
                end
            end
            if (!(w > 0 && h > 0)) return 0;
            r.f[0] = x[W:0]; r.f[1] = y[W:0]; r.f[2] = w[W:0]; r.f[3] = h[W:0];
            r.f[4] = tx[W:0]; r.f[5] = ty[W:0]; r.f[6] = tw[W:0]; r.f[7] = th[W:0];
            return 1;
        end
        x = p.v[0] + org_x; y = p.v[1] + org_y;
        xb = p.v[2] + org_x; yb = p.v[3] + org_y;
        if (x > xb) begin
            t = x; x = xb; xb = t;
            t = y; y = yb; yb = t;
        end
        if (on) begin
            if (x > sc_right && xb > sc_right) return 0;
            if (x < sc_left && xb < sc_left) return 0;
            if (y > sc_bottom && yb > sc_bottom) return 0;
            if (y < sc_top && yb < sc_top) return 0;
            if (x < sc_left) begin
                if (x == xb) return 0;
                y += qdiv((sc_left - x) * (yb - y), xb - x); x = sc_left;
            end
            if (xb > sc_right) begin
                if (x == xb) return 0;
                yb += qdiv((sc_right - xb) * (yb - y), xb - x); xb = sc_right;
            end
            if (y < sc_top) begin
                if (y == yb) return 0;
                x += qdiv((sc_top - y) * (xb - x), yb - y); y = sc_top;
            end
            if (yb < sc_top) begin
                if (y == yb) return 0;
                xb += qdiv((sc_top - yb) * (xb - x), yb - y); yb = sc_top;
            end
            if (y > sc_bottom) begin
                if (y == yb) return 0;
                x += qdiv((sc_bottom - y) * (xb - x), yb - y); y = sc_bottom;
            end
            if (yb > sc_bottom) begin
                if (y == yb) return 0;
                xb += qdiv((sc_bottom - yb) * (xb - x), yb - y); yb = sc_bottom;
            end
        end
        if (x == xb && y == yb) return 0;
        r.f[0] = x[W:0]; r.f[1] = y[W:0]; r.f[2] = xb[W:0]; r.f[3] = yb[W:0];
        for (int i = 4; i < 8; i++) r.f[i] = '0;
        return 1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        clip_t got, want;
        bit bad;
        if (i_rst_n && o_valid) begin
            got.kind = o_out_kind;
            got.f[0] = o_out_x; got.f[1] = o_out_y;
            got.f[2] = o_out_w_or_end_x; got.f[3] = o_out_h_or_end_y;
            got.f[4] = o_out_tex_x; got.f[5] = o_out_tex_y;
            got.f[6] = o_out_tex_w; got.f[7] = o_out_tex_h;
            if (clip_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result kind %0d x %0d y %0d",
                    got.kind, got.f[0], got.f[1]);
            end else begin
                want = clip_q.pop_front();
                bad = got.kind !== want.kind;
                for (int i = 0; i < 8; i++) bad |= got.f[i] !== want.f[i];
                if (bad) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch exp kind %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                            want.kind, want.f[0], want.f[1], want.f[2], want.f[3],
                            want.f[4], want.f[5], want.f[6], want.f[7]);
                        $display("         got kind %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                            got.kind, got.f[0], got.f[1], got.f[2], got.f[3],
                            got.f[4], got.f[5], got.f[6], got.f[7]);
                    end
                end
            end
        end
    end

    function automatic void add_row(int ph, chk_t how, logic k, vec8_t v, vec8_t e);
        row_t r;
        r.ph = ph; r.how = how; r.p.kind = k; r.p.v = v; r.e = e;
        rows.push_back(r);
    endfunction

    function automatic longint rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2: return $signed(16'($urandom));
            default: return longint'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    task automatic drain();
        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, longint val);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[W-1:0];
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SC_LEFT:   sc_left = $signed(val[W-1:0]);
            CFG_SC_TOP:    sc_top = $signed(val[W-1:0]);
            CFG_SC_RIGHT:  sc_right = $signed(val[W-1:0]);
            CFG_SC_BOTTOM: sc_bottom = $signed(val[W-1:0]);
            CFG_ORG_X:     org_x = $signed(val[W-1:0]);
            default:       org_y = $signed(val[W-1:0]);
        endcase
    endtask

    task automatic load_scissor(vec6_t c);
        drain();
        write_reg(CFG_SC_LEFT, c[0]);
        write_reg(CFG_SC_TOP, c[1]);
        write_reg(CFG_SC_RIGHT, c[2]);
        write_reg(CFG_SC_BOTTOM, c[3]);
        write_reg(CFG_ORG_X, c[4]);
        write_reg(CFG_ORG_Y, c[5]);
    endtask

    // drives one primitive, leaves start high; returns after the accepting edge
    task automatic send_prim(prim_t p, chk_t how, vec8_t e);
        clip_t r;
        bit ok;
        i_start <= 1'b1;
        i_kind <= p.kind;
        i_pos_x <= p.v[0][W-1:0];
        i_pos_y <= p.v[1][W-1:0];
        i_size_w_or_end_x <= p.v[2][W-1:0];
        i_size_h_or_end_y <= p.v[3][W-1:0];
        i_tex_x <= p.v[4][W-1:0];
        i_tex_y <= p.v[5][W-1:0];
        i_tex_w <= p.v[6][W-1:0];
        i_tex_h <= p.v[7][W-1:0];
        do begin
            @(negedge i_clk);
            ok = !o_busy;
            @(posedge i_clk);
        end while (!ok);
        if (how == CHK_TYPED) begin
            r.kind = p.kind;
            for (int i = 0; i < 8; i++) r.f[i] = e[i][W:0];
            clip_q.push_back(r);
        end else if (how == CHK_MODEL) begin
            if (clip_prim(p, r)) clip_q.push_back(r);
        end
    endtask

    task automatic idle_burst();
        i_start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge i_clk);
    endtask

    initial begin
        vec8_t z;
        vec6_t ph_cfg [4];
        vec6_t c;
        prim_t p;
        int cur_ph;
        longint a, b;

        z = '{0, 0, 0, 0, 0, 0, 0, 0};
        ph_cfg[1] = '{10, 20, 100, 80, 5, -3};
        ph_cfg[2] = '{-32768, -32768, 32767, 32767, 32767, -32768};
        ph_cfg[3] = '{100, 0, -100, 50, -32768, 32767};

        // reset values, scissor off
        add_row(0, CHK_TYPED, KIND_RECT, '{5, 6, 3, 4, 1, 2, 3, 4}, '{5, 6, 3, 4, 1, 2, 3, 4});
        add_row(0, CHK_NONE, KIND_RECT, '{5, 6, 0, 4, 1, 2, 3, 4}, z);
        add_row(0, CHK_NONE, KIND_RECT, '{5, 6, 3, -4, 1, 2, 3, 4}, z);
        add_row(0, CHK_TYPED, KIND_LINE, '{3, 4, 1, 2, 9, 9, 9, 9}, '{1, 2, 3, 4, 0, 0, 0, 0});
        add_row(0, CHK_NONE, KIND_LINE, '{7, 7, 7, 7, 1, 1, 1, 1}, z);
        add_row(0, CHK_TYPED, KIND_RECT,
            '{-32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767},
            '{-32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767});
        add_row(0, CHK_TYPED, KIND_LINE, '{32767, -32768, -32768, 32767, 0, 0, 0, 0},
            '{-32768, 32767, 32767, -32768, 0, 0, 0, 0});
        // small scissor with origin
        add_row(1, CHK_MODEL, KIND_RECT, '{-20, 0, 60, 40, 7, 9, 100, -50}, z);
        add_row(1, CHK_MODEL, KIND_RECT, '{50, 10, 200, 300, -3, 4, 64, 64}, z);
        add_row(1, CHK_MODEL, KIND_RECT, '{-100, -100, 0, 0, 1, 1, 5, 5}, z);
        add_row(1, CHK_MODEL, KIND_RECT, '{-100, 30, 120, 10, 0, 0, 77, 33}, z);
        add_row(1, CHK_MODEL, KIND_LINE, '{-50, -40, 200, 150, 0, 0, 0, 0}, z);
        add_row(1, CHK_MODEL, KIND_LINE, '{200, 10, -50, 90, 0, 0, 0, 0}, z);
        add_row(1, CHK_MODEL, KIND_LINE, '{300, 30, 400, 40, 0, 0, 0, 0}, z);
        add_row(1, CHK_MODEL, KIND_LINE, '{40, -90, 40, 200, 0, 0, 0, 0}, z);
        add_row(1, CHK_MODEL, KIND_LINE, '{-200, 200, -199, -200, 0, 0, 0, 0}, z);
        // extreme scissor and origin
        add_row(2, CHK_MODEL, KIND_RECT,
            '{-32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767}, z);
        add_row(2, CHK_MODEL, KIND_RECT,
            '{-32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768}, z);
        add_row(2, CHK_MODEL, KIND_LINE, '{-32768, 32767, 32767, -32768, 0, 0, 0, 0}, z);
        add_row(2, CHK_MODEL, KIND_LINE, '{32767, 32767, -32768, -32768, 0, 0, 0, 0}, z);
        // scissor off, origin wraps nothing
        add_row(3, CHK_MODEL, KIND_RECT, '{-5, 7, 10, 10, 1, 2, 3, 4}, z);
        add_row(3, CHK_MODEL, KIND_LINE, '{5, 7, -5, -7, 0, 0, 0, 0}, z);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_ph = 0;
        foreach (rows[i]) begin
            if (rows[i].ph != cur_ph) begin
                i_start <= 1'b0;
                cur_ph = rows[i].ph;
                load_scissor(ph_cfg[cur_ph]);
            end
            send_prim(rows[i].p, rows[i].how, rows[i].e);
            if ($urandom_range(0, 3) == 0) idle_burst();
        end
        i_start <= 1'b0;

        for (int n = 0; n < N_RAND; n++) begin
            if (n % 150 == 0) begin
                i_start <= 1'b0;
                case ($urandom_range(0, 5))
                    0: c = ph_cfg[2];
                    1: c = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord()};
                    default: begin
                        a = longint'($urandom_range(0, 300)) - 200;
                        b = longint'($urandom_range(0, 300)) - 200;
                        c = '{a, b, a + $urandom_range(0, 250), b + $urandom_range(0, 250),
                              longint'($urandom_range(0, 100)) - 50,
                              longint'($urandom_range(0, 100)) - 50};
                    end
                endcase
                load_scissor(c);
            end
            if (n == 700) begin
                i_start <= 1'b0;
                while (clip_q.size() != 0) @(posedge i_clk);
            end
            p.kind = $urandom_range(0, 1);
            for (int i = 0; i < 8; i++) p.v[i] = rnd_coord();
            if (p.kind == KIND_RECT && $urandom_range(0, 1))
                for (int i = 2; i < 4; i++) p.v[i] = $urandom_range(0, 300);
            send_prim(p, CHK_MODEL, z);
            if (n < N_RAND - N_CALM && $urandom_range(0, 5) == 0) idle_burst();
        end
        i_start <= 1'b0;

        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
